// ===== sv/assert_macros.svh =====
// Assertion macros shared by the verification files of the UTF-8 decoder.
// Depends on nothing; the using scope must provide clock and reset signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define UTF8D_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/utf8d_pkg.sv =====
// Package of the UTF-8 decoder: constants, error kinds, control structs and
// the single-step decode function. Depends on nothing.
package utf8d_pkg;

   localparam int POSITION_BITS = 32;
   localparam int POS_OUT_BITS  = 32;
   localparam int BUF_DEPTH     = 4;

   localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;

   // error kinds
   localparam logic [3:0] KIND_NONE      = 4'd0;
   localparam logic [3:0] KIND_STRAY     = 4'd1;
   localparam logic [3:0] KIND_C0_C1     = 4'd2;
   localparam logic [3:0] KIND_TRUNCATED = 4'd3;
   localparam logic [3:0] KIND_BAD_CONT  = 4'd4;
   localparam logic [3:0] KIND_OVERLONG  = 4'd5;
   localparam logic [3:0] KIND_SURROGATE = 4'd6;
   localparam logic [3:0] KIND_ABOVE     = 4'd7;
   localparam logic [3:0] KIND_F5_FF     = 4'd8;

   localparam logic [7:0] LEAD_MIN_2 = 8'hC2;
   localparam logic [7:0] LEAD_MIN_3 = 8'hE0;
   localparam logic [7:0] LEAD_SURR  = 8'hED;
   localparam logic [7:0] LEAD_MIN_4 = 8'hF0;
   localparam logic [7:0] LEAD_MAX_4 = 8'hF4;
   localparam logic [7:0] LEAD_BAD   = 8'hF5;
   localparam logic [7:0] CONT_A0    = 8'hA0;
   localparam logic [7:0] CONT_90    = 8'h90;

   typedef logic [BUF_DEPTH-1:0][7:0] buf_type;

   typedef struct packed {
      logic        brk;      // sequence incomplete, wait for more bytes
      logic [20:0] cp;
      logic [3:0]  kind;
      logic [2:0]  consume;  // bytes used by this result
   } step_type;

   typedef struct packed {
      logic load;  // take the incoming byte into the buffer
      logic step;  // decode one result at the head of the buffer
   } cmd_type;

   typedef struct packed {
      logic brk;       // head of the buffer needs more bytes
      logic last;      // the result of this step ends the run
      logic out_free;  // result register can take a new result
   } status_type;

   function automatic step_type decode_step(buf_type b, logic [2:0] cnt, logic eot);
      step_type   s;
      logic [7:0] lead;
      logic [2:0] need;
      logic       bad;
      lead      = b[0];
      s.brk     = 1'b0;
      s.cp      = REPLACEMENT_CHAR;
      s.kind    = KIND_NONE;
      s.consume = 3'd1;
      need      = (lead < LEAD_MIN_3) ? 3'd2 : ((lead < LEAD_MIN_4) ? 3'd3 : 3'd4);
      bad       = (b[1][7:6] != 2'b10)
                  || ((need >= 3'd3) && (b[2][7:6] != 2'b10))
                  || ((need == 3'd4) && (b[3][7:6] != 2'b10));
      if (lead[7] == 1'b0) begin
         s.cp = {13'd0, lead};
      end else if (lead < 8'hC0) begin
         s.kind = KIND_STRAY;
      end else if (lead < LEAD_MIN_2) begin
         s.kind = KIND_C0_C1;
      end else if (lead >= LEAD_BAD) begin
         s.kind = KIND_F5_FF;
      end else if (need > cnt) begin
         if (eot) s.kind = KIND_TRUNCATED;
         else s.brk = 1'b1;
      end else if (bad) begin
         s.kind = KIND_BAD_CONT;
      end else if ((lead == LEAD_MIN_3) && (b[1] < CONT_A0)) begin
         s.kind = KIND_OVERLONG;
      end else if ((lead == LEAD_SURR) && (b[1] >= CONT_A0)) begin
         s.kind = KIND_SURROGATE;
      end else if ((lead == LEAD_MIN_4) && (b[1] < CONT_90)) begin
         s.kind = KIND_OVERLONG;
      end else if ((lead == LEAD_MAX_4) && (b[1] >= CONT_90)) begin
         s.kind = KIND_ABOVE;
      end else begin
         s.consume = need;
         if (need == 3'd2) s.cp = {10'd0, lead[4:0], b[1][5:0]};
         else if (need == 3'd3) s.cp = {5'd0, lead[3:0], b[1][5:0], b[2][5:0]};
         else s.cp = {lead[2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      end
      return s;
   endfunction

endpackage

// ===== sv/utf8d_if.sv =====
// Handshake channels of the UTF-8 decoder: byte request and code point response.
// Depends on nothing.
interface utf8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_text;

   modport source (output valid, byte_value, end_of_text, input ready);
   modport sink   (input valid, byte_value, end_of_text, output ready);
endinterface

interface utf8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        is_error;
   logic [3:0]  error_kind;
   logic [31:0] error_position;
   logic        last_of_run;
   logic        text_done;

   modport source (output valid, code_point, is_error, error_kind, error_position,
                   last_of_run, text_done, input ready);
   modport sink   (input valid, code_point, is_error, error_kind, error_position,
                   last_of_run, text_done, output ready);
endinterface

// ===== sv/utf8d_ctrl.sv =====
// Controller of the UTF-8 decoder: takes a byte, then steps the datapath
// once per result. Depends on utf8d_pkg.
module utf8d_ctrl import utf8d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_RUN  = 1'b1;

   logic state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = STATE_RUN;
            end
         end
         STATE_RUN: begin
            if (status.brk) begin
               state_in = STATE_IDLE;
            end else if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.last) state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= STATE_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== sv/utf8d_datapath.sv =====
// Datapath of the UTF-8 decoder: byte buffer, lead position, step decode and
// result register. Depends on utf8d_pkg.
module utf8d_datapath import utf8d_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [7:0]               byte_value,
   input  logic                     end_of_text,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [20:0]              code_point,
   output logic                     is_error,
   output logic [3:0]               error_kind,
   output logic [POS_OUT_BITS-1:0]  error_position,
   output logic                     last_of_run,
   output logic                     text_done
);

   buf_type                  buf_ff, buf_in, buf_sh;
   logic [2:0]               cnt_ff, cnt_in, cnt_next;
   logic                     eot_ff;
   logic [POSITION_BITS-1:0] lead_pos_ff, lead_pos_in;
   step_type                 cur, after;
   logic                     last;

   logic                     rsp_valid_ff;
   logic [20:0]              cp_ff;
   logic [3:0]               kind_ff;
   logic [POS_OUT_BITS-1:0]  pos_ff;
   logic                     last_ff, done_ff;

   assign cur      = decode_step(buf_ff, cnt_ff, eot_ff);
   assign cnt_next = cnt_ff - cur.consume;

   // drop the consumed bytes from the head
   always_comb begin
      for (int e = 0; e < BUF_DEPTH; e++) begin
         buf_sh[e] = buf_ff[e];
         case (cur.consume)
            3'd1: if (e + 1 < BUF_DEPTH) buf_sh[e] = buf_ff[e+1];
            3'd2: if (e + 2 < BUF_DEPTH) buf_sh[e] = buf_ff[e+2];
            3'd3: if (e + 3 < BUF_DEPTH) buf_sh[e] = buf_ff[e+3];
            default: buf_sh[e] = buf_ff[e];
         endcase
      end
   end

   assign after = decode_step(buf_sh, cnt_next, eot_ff);
   assign last  = (cnt_next == 3'd0) || after.brk;

   assign status.brk      = cur.brk;
   assign status.last     = last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      lead_pos_in = lead_pos_ff;
      if (cmd.load) begin
         for (int e = 0; e < BUF_DEPTH; e++)
            if (cnt_ff[1:0] == 2'(e)) buf_in[e] = byte_value;
         cnt_in = cnt_ff + 3'd1;
      end else if (cmd.step) begin
         buf_in      = buf_sh;
         cnt_in      = cnt_next;
         lead_pos_in = lead_pos_ff + POSITION_BITS'(cur.consume);
         if (last && eot_ff) begin
            cnt_in      = 3'd0;
            lead_pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (cmd.load) eot_ff <= end_of_text;
      if (cmd.step) begin
         cp_ff   <= cur.cp;
         kind_ff <= cur.kind;
         pos_ff  <= (cur.kind != KIND_NONE) ? POS_OUT_BITS'(lead_pos_ff) : '0;
         last_ff <= last;
         done_ff <= last && eot_ff;
      end
      if (reset) begin
         cnt_ff       <= 3'd0;
         lead_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         lead_pos_ff <= lead_pos_in;
         if (cmd.step) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign code_point     = cp_ff;
   assign is_error       = (kind_ff != KIND_NONE);
   assign error_kind     = kind_ff;
   assign error_position = pos_ff;
   assign last_of_run    = last_ff;
   assign text_done      = done_ff;

endmodule

// ===== sv/utf8_decoder_with_replacement.sv =====
// Strict UTF-8 decoder with U+FFFD replacement. Bytes come in one per transfer
// on req_if; code points leave on rsp_if. Overlong forms, surrogates, values
// above U+10FFFF, stray continuations and leads C0, C1 and F5..FF are each
// replaced by U+FFFD with an error kind and the byte offset of the rejected
// lead within the text. After a rejected lead, decoding restarts at the next
// byte, so bytes of the failed sequence are decoded again. Bytes of an
// incomplete sequence are held (up to three) and give no result until the
// sequence completes or the text ends; the last result of a byte carries
// last_of_run, and the last result of the text also carries text_done, after
// which the offset starts again at zero. Timing: a byte transfers in while the
// controller is idle, then the datapath steps once per result it releases (one
// to four), or the controller just finds the sequence still incomplete when it
// releases none; a step waits while the result register is held downstream.
// All results of a byte are stepped in turn through the one result register,
// and the controller takes a byte only while idle, so a new byte is taken only
// after the last result of the previous one is stepped. The result register
// lets the next byte transfer in while the last result still waits downstream.
// Depends on utf8d_pkg, utf8d_if, utf8d_ctrl and utf8d_datapath.
module utf8_decoder_with_replacement import utf8d_pkg::*; (
   input logic         clock,
   input logic         reset,
   utf8d_req_if.sink   req_if,
   utf8d_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;

   // controller: accept a byte in idle, then issue one step per result
   utf8d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: hold bytes, decode the head of the buffer, register the result
   utf8d_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .byte_value     (req_if.byte_value),
      .end_of_text    (req_if.end_of_text),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .code_point     (rsp_if.code_point),
      .is_error       (rsp_if.is_error),
      .error_kind     (rsp_if.error_kind),
      .error_position (rsp_if.error_position),
      .last_of_run    (rsp_if.last_of_run),
      .text_done      (rsp_if.text_done)
   );

endmodule

// ===== sv/utf8d_checker.sv =====
// Port-level checks of the UTF-8 decoder, bound to its top level.
// Depends on assert_macros.svh and utf8d_pkg.
`include "assert_macros.svh"

module utf8d_checker import utf8d_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] rsp_code_point,
   input logic        rsp_is_error,
   input logic [3:0]  rsp_error_kind,
   input logic [31:0] rsp_error_position,
   input logic        rsp_last_of_run,
   input logic        rsp_text_done
);

   logic err_vld, ok_vld, done_vld, stalled;
   logic is_fffd, ok_clean, ok_scalar;

   assign err_vld   = rsp_valid && rsp_is_error;
   assign ok_vld    = rsp_valid && !rsp_is_error;
   assign done_vld  = rsp_valid && rsp_text_done;
   assign stalled   = rsp_valid && !rsp_ready;
   assign is_fffd   = (rsp_code_point == REPLACEMENT_CHAR);
   assign ok_clean  = (rsp_error_kind == KIND_NONE) && (rsp_error_position == '0);
   assign ok_scalar = (rsp_code_point <= 21'h10FFFF)
                      && ((rsp_code_point < 21'h00D800) || (rsp_code_point > 21'h00DFFF));

   // a rejected byte always reads as the replacement character
   `UTF8D_ASSERT(a_err_is_fffd, !err_vld || is_fffd, "error result without U+FFFD")

   // a good result has no kind and no position
   `UTF8D_ASSERT(a_ok_clean, !ok_vld || ok_clean, "good result with error data")

   // a good result is a Unicode scalar value
   `UTF8D_ASSERT(a_ok_scalar, !ok_vld || ok_scalar, "good result out of scalar range")

   // the end of the text also ends the run
   `UTF8D_ASSERT(a_done_last, !done_vld || rsp_last_of_run, "text_done without last_of_run")

   // a stalled result stays offered
   `UTF8D_ASSERT_NEXT(a_hold, stalled, rsp_valid && $stable(rsp_code_point), "result dropped")

endmodule

bind utf8_decoder_with_replacement utf8d_checker u_utf8d_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_code_point     (rsp_if.code_point),
   .rsp_is_error       (rsp_if.is_error),
   .rsp_error_kind     (rsp_if.error_kind),
   .rsp_error_position (rsp_if.error_position),
   .rsp_last_of_run    (rsp_if.last_of_run),
   .rsp_text_done      (rsp_if.text_done)
);

// ===== sim/tb_utf8_decoder_with_replacement.sv =====
// Self-checking testbench of the strict UTF-8 decoder with U+FFFD replacement.
// Depends on utf8d_pkg, utf8d_if and utf8_decoder_with_replacement.
module tb_utf8_decoder_with_replacement;
   import utf8d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Quiet cycles allowed before the run is declared hung. The slowest legal
   // transfer is a sender gap plus a long receiver stall, well under this.
   localparam int QUIET_LIMIT = 2000;

   // One decoded code point as it should leave the block.
   typedef struct packed {
      logic [20:0] code_point;
      logic        is_error;
      logic [3:0]  error_kind;
      logic [31:0] error_position;
      logic        last_of_run;
      logic        text_done;
   } cp_result_type;

   typedef logic [7:0] octet_q_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_ready = 1'b0;

   utf8d_req_if req_if ();
   utf8d_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_ready;

   utf8_decoder_with_replacement i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #2 clock = ~clock;

   // Decoder state mirrored by the testbench.
   logic [7:0]  held_seq [0:2];
   int          held_n   = 0;
   logic [31:0] text_pos = '0;

   cp_result_type predicted_cps[$];
   octet_q_type   text_buf;
   int          errors     = 0;
   int          bytes_sent = 0;
   int          burst_left = 0;
   logic        back_to_back = 1'b0;

   // ------------------------------------------------------------------
   // Predictor: run one byte through the strict decoder and queue every
   // code point it releases. Truncation is checked before continuation
   // bytes, and continuation bytes before the range checks. A rejected
   // lead consumes only itself, so the bytes behind it are decoded again.
   // ------------------------------------------------------------------
   function automatic void decode_byte(input logic [7:0] value, input logic eot);
      logic [7:0]    seq [0:3];
      cp_result_type run [0:3];
      logic [31:0]   lead_pos;
      logic [7:0]    lead;
      logic [3:0]    kind;
      logic [20:0]   cp;
      int            n, i, k, need, used, cnt;
      bit            wait_more;
      for (k = 0; k < held_n; k++) seq[k] = held_seq[k];
      seq[held_n] = value;
      n = held_n + 1;
      i = 0;
      cnt = 0;
      wait_more = 1'b0;
      while (i < n && !wait_more) begin
         lead     = seq[i];
         lead_pos = text_pos - held_n + i;
         kind     = KIND_NONE;
         cp       = REPLACEMENT_CHAR;
         used     = 1;
         need     = (lead < LEAD_MIN_3) ? 2 : ((lead < LEAD_MIN_4) ? 3 : 4);
         if (!lead[7]) begin
            cp = {13'd0, lead};
         end else if (lead < 8'hC0) begin
            kind = KIND_STRAY;
         end else if (lead < LEAD_MIN_2) begin
            kind = KIND_C0_C1;
         end else if (lead >= LEAD_BAD) begin
            kind = KIND_F5_FF;
         end else if (i + need > n) begin
            // hold the sequence unless the text ends here
            if (eot) kind = KIND_TRUNCATED;
            else wait_more = 1'b1;
         end else begin
            for (k = 1; k < need; k++)
               if (seq[i+k][7:6] != 2'b10) kind = KIND_BAD_CONT;
            if (kind == KIND_NONE) begin
               if (lead == LEAD_MIN_3 && seq[i+1] < CONT_A0) kind = KIND_OVERLONG;
               else if (lead == LEAD_SURR && seq[i+1] >= CONT_A0) kind = KIND_SURROGATE;
               else if (lead == LEAD_MIN_4 && seq[i+1] < CONT_90) kind = KIND_OVERLONG;
               else if (lead == LEAD_MAX_4 && seq[i+1] >= CONT_90) kind = KIND_ABOVE;
            end
            if (kind == KIND_NONE) begin
               used = need;
               case (need)
                  2: cp = {10'd0, lead[4:0], seq[i+1][5:0]};
                  3: cp = {5'd0, lead[3:0], seq[i+1][5:0], seq[i+2][5:0]};
                  default: cp = {lead[2:0], seq[i+1][5:0], seq[i+2][5:0], seq[i+3][5:0]};
               endcase
            end
         end
         if (!wait_more) begin
            run[cnt] = '{cp, kind != KIND_NONE, kind,
                         (kind != KIND_NONE) ? lead_pos : 32'd0, 1'b0, 1'b0};
            cnt++;
            i += used;
         end
      end
      if (cnt > 0) begin
         run[cnt-1].last_of_run = 1'b1;
         run[cnt-1].text_done   = eot;
      end
      for (k = 0; k < cnt; k++) predicted_cps = {predicted_cps, run[k]};
      held_n = eot ? 0 : n - i;
      for (k = 0; k < held_n; k++) held_seq[k] = seq[i+k];
      text_pos = eot ? 32'd0 : text_pos + 32'd1;
   endfunction

   // ------------------------------------------------------------------
   // Text builders
   // ------------------------------------------------------------------
   function automatic void append_octet(input logic [7:0] value);
      text_buf = {text_buf, value};
   endfunction

   function automatic logic [7:0] rand_cont();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // Append the shortest-form encoding of a random scalar value.
   function automatic void add_scalar();
      logic [20:0] cp;
      case ($urandom_range(0, 3))
         0: begin
            cp = 21'($urandom_range(0, 'h7F));
            append_octet(cp[7:0]);
         end
         1: begin
            cp = 21'($urandom_range('h80, 'h7FF));
            append_octet({3'b110, cp[10:6]});
            append_octet({2'b10, cp[5:0]});
         end
         2: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            // skip the surrogate block
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
            append_octet({4'b1110, cp[15:12]});
            append_octet({2'b10, cp[11:6]});
            append_octet({2'b10, cp[5:0]});
         end
         default: begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
            append_octet({5'b11110, cp[20:18]});
            append_octet({2'b10, cp[17:12]});
            append_octet({2'b10, cp[11:6]});
            append_octet({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // Append a malformed or borderline fragment.
   function automatic void add_noise();
      case ($urandom_range(0, 5))
         0: append_octet(8'($urandom_range(0, 255)));
         1: begin
            // multi-byte lead cut short
            append_octet(8'($urandom_range('hE0, 'hF4)));
            repeat ($urandom_range(0, 1)) append_octet(rand_cont());
         end
         2: begin
            case ($urandom_range(0, 2))
               0: append_octet(8'($urandom_range('hC0, 'hC1)));
               1: begin
                  append_octet(LEAD_MIN_3);
                  append_octet(8'($urandom_range('h80, 'h9F)));
               end
               default: begin
                  append_octet(LEAD_MIN_4);
                  append_octet(8'($urandom_range('h80, 'h8F)));
                  append_octet(rand_cont());
               end
            endcase
            append_octet(rand_cont());
         end
         3: begin
            append_octet(LEAD_SURR);
            append_octet(8'($urandom_range('hA0, 'hBF)));
            append_octet(rand_cont());
         end
         4: begin
            if ($urandom_range(0, 1)) begin
               append_octet(LEAD_MAX_4);
               append_octet(8'($urandom_range('h90, 'hBF)));
               append_octet(rand_cont());
               append_octet(rand_cont());
            end else begin
               append_octet(8'($urandom_range('hF5, 'hFF)));
            end
         end
         default: begin
            // valid lead followed by a byte that is not a continuation
            append_octet(8'($urandom_range('hC2, 'hF4)));
            if ($urandom_range(0, 1)) append_octet(8'($urandom_range(0, 'h7F)));
            else append_octet(8'($urandom_range('hC0, 'hFF)));
            append_octet(rand_cont());
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps. Valid stays
   // high across a burst; it drops only when a gap opens.
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value, input logic eot);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0 || back_to_back) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.byte_value  <= value;
      req_if.end_of_text <= eot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // the transfer happened at this edge
      decode_byte(value, eot);
      bytes_sent++;
   endtask

   // Send the built text, flagging its final byte as the end of the text.
   task automatic send_text();
      int k;
      for (k = 0; k < text_buf.size(); k++) send_byte(text_buf[k], k == text_buf.size() - 1);
      text_buf.delete();
   endtask

   // Mostly well-formed texts with random content, the rest noise.
   task automatic send_random_texts(input int count);
      int stop_at, units, u;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         units = $urandom_range(1, 8);
         for (u = 0; u < units; u++)
            if ($urandom_range(0, 3) != 0) add_scalar();
            else add_noise();
         send_text();
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Smallest and largest values of each encoding length that is legal.
   task automatic test_valid_extremes();
      text_buf = '{8'h00, 8'h7F,
                   8'hC2, 8'h80, 8'hDF, 8'hBF,
                   8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                   8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
   endtask

   // Every error kind: stray continuation, C0/C1 and F5..FF leads, overlong,
   // surrogate, bad continuation (found only once the sequence is full),
   // above U+10FFFF with four results from one byte, and a lead truncated
   // by the end of the text.
   task automatic test_error_kinds();
      text_buf = '{8'h80, 8'hC1, 8'hF5, 8'hFF,
                   8'hE0, 8'h9F, 8'h80,
                   8'hED, 8'hA0, 8'h80,
                   8'hE2, 8'h41,
                   8'hF4, 8'h90, 8'h80, 8'h80,
                   8'hE2, 8'h82};
      send_text();
   endtask

   task automatic test_random_texts();
      send_random_texts(45);
   endtask

   // Full rate on both sides: no sender gaps, no receiver stalls.
   task automatic test_back_to_back();
      back_to_back = 1'b1;
      send_random_texts(20);
      back_to_back = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver: ready follows a rotating random pattern that is reloaded
   // now and then; some stretches never stall, some stall heavily.
   // ------------------------------------------------------------------
   int          stall_left = 0;
   int          stall_mode = 0;
   logic [31:0] stall_pat  = '1;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(16, 64);
         stall_mode = $urandom_range(0, 2);
         stall_pat  = $urandom;
         if (stall_mode == 2) stall_pat = stall_pat & $urandom;
         stall_pat[0] = 1'b1;
      end
      stall_left--;
      stall_pat = {stall_pat[0], stall_pat[31:1]};
      rsp_ready <= back_to_back || stall_mode == 0 || stall_pat[0];
   end

   // ------------------------------------------------------------------
   // Checker: compare each transfer with the oldest predicted code point.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      cp_result_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.code_point, rsp_if.is_error, rsp_if.error_kind,
                 rsp_if.error_position, rsp_if.last_of_run, rsp_if.text_done};
         if (predicted_cps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result cp=%h err=%b kind=%0d pos=%0d last=%b done=%b",
                     $time, got.code_point, got.is_error, got.error_kind,
                     got.error_position, got.last_of_run, got.text_done);
         end else begin
            want = predicted_cps.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch exp cp=%h err=%b kind=%0d pos=%0d last=%b done=%b",
                        $time, want.code_point, want.is_error, want.error_kind,
                        want.error_position, want.last_of_run, want.text_done);
               $display("%0t:          got cp=%h err=%b kind=%0d pos=%0d last=%b done=%b",
                        $time, got.code_point, got.is_error, got.error_kind,
                        got.error_position, got.last_of_run, got.text_done);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if neither side transfers for too long.
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_if.valid       = 1'b0;
      req_if.byte_value  = 8'h00;
      req_if.end_of_text = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_valid_extremes();
      test_error_kinds();
      test_random_texts();
      test_back_to_back();

      // drop valid, drain what is still owed, then allow a few idle cycles
      req_if.valid <= 1'b0;
      while (predicted_cps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
